// ===== design/tcrm_pkg.sv =====
// Shared constants, types and a helper function for the triple comb resonator mix block.
// Used by the controller, the datapath and the top level.
package tcrm_pkg;

	localparam int LINE_DEPTH  = 4096;
	localparam int LINE_W      = $clog2(LINE_DEPTH);
	localparam int COMB_COUNT  = 3;

	localparam int SAMPLE_W    = 16;
	localparam int DELAY_W     = 12;
	localparam int DECAY_W     = 16;
	localparam int MIX_W       = 17;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 17;

	localparam logic [DELAY_W-1:0] DELAY_RESET = DELAY_W'(100);
	localparam logic [MIX_W-1:0]   MIX_FULL    = MIX_W'(65536);

	// Rounded divide by three: floor((2s + 3) / 6) via reciprocal multiply.
	localparam int SUM_W       = 18;
	localparam int DIVN_W      = 20;
	localparam int RECIP_W     = 21;
	localparam int DIV_SHIFT   = 23;
	localparam int DIVP_W      = DIVN_W + RECIP_W;
	localparam int QUOT_W      = DIVP_W - DIV_SHIFT;
	localparam logic [RECIP_W-1:0] DIV_RECIP  = RECIP_W'(1398102);
	localparam logic signed [20:0] DIV_BIAS   = 21'sd786435;
	localparam logic [QUOT_W-1:0]  DIV_OFFSET = QUOT_W'(131072);

	localparam int SAT_W       = 20;

	localparam logic [CFG_IDX_W-1:0] CFG_ENABLE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DELAY0 = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_DELAY1 = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_DELAY2 = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_DECAY  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_MIX    = 3'd5;

	typedef struct packed {
		logic              clear;
		logic [LINE_W-1:0] clr_addr;
		logic              accept;
		logic              mul;
		logic              acc;
		logic              div;
		logic              mix;
		logic              load;
	} ctrl_cmd_t;

	typedef struct packed {
		logic enable;
	} dp_status_t;

	function automatic logic signed [SAMPLE_W-1:0] sat16(input logic signed [SAT_W-1:0] v);
		logic signed [SAT_W-1:0] hi;
		logic signed [SAT_W-1:0] lo;
		hi = SAT_W'(32767);
		lo = -SAT_W'(32768);
		if (v > hi) begin
			return 16'sh7FFF;
		end else if (v < lo) begin
			return 16'sh8000;
		end
		return v[SAMPLE_W-1:0];
	endfunction

endpackage

// ===== design/tcrm_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
module tcrm_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== design/tcrm_ctrl.sv =====
// Controller state machine: delay line clearing pass, item sequencing, output register handshake.
// Depends on tcrm_pkg.
module tcrm_ctrl import tcrm_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	output logic       out_valid,
	input  logic       out_stall,
	input  dp_status_t status,
	output ctrl_cmd_t  cmd
);

	localparam logic [2:0] ST_CLEAR = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_MUL   = 3'd2;
	localparam logic [2:0] ST_ACC   = 3'd3;
	localparam logic [2:0] ST_DIV   = 3'd4;
	localparam logic [2:0] ST_MIX   = 3'd5;
	localparam logic [2:0] ST_FIN   = 3'd6;

	localparam logic [LINE_W-1:0] CLR_LAST = LINE_W'(LINE_DEPTH - 1);

	logic [2:0]        state_q;
	logic [2:0]        state_d;
	logic [LINE_W-1:0] clr_q;
	logic              out_valid_q;
	logic              out_free;

	assign out_free  = !out_valid_q || !out_stall;
	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd          = '0;
		cmd.clr_addr = clr_q;
		state_d      = state_q;
		case (state_q)
			ST_CLEAR: begin
				cmd.clear = 1'b1;
				if (clr_q == CLR_LAST) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_d    = status.enable ? ST_MUL : ST_FIN;
				end
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = ST_ACC;
			end
			ST_ACC: begin
				cmd.acc = 1'b1;
				state_d = ST_DIV;
			end
			ST_DIV: begin
				cmd.div = 1'b1;
				state_d = ST_MIX;
			end
			ST_MIX: begin
				cmd.mix = 1'b1;
				state_d = ST_FIN;
			end
			ST_FIN: begin
				if (out_free) begin
					cmd.load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + LINE_W'(1);
			end
			if (cmd.load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR) |-> !cmd.accept)
		else $error("transaction accepted during clearing pass");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR && clr_q == CLR_LAST) |=> (state_q == ST_IDLE))
		else $error("clearing pass did not finish");

	assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.accept && status.enable) |=> (state_q == ST_MUL))
		else $error("enabled transaction skipped comb update");

	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> !(out_valid_q && out_stall))
		else $error("output overwritten while stalled");

	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.acc |=> (state_q == ST_DIV))
		else $error("delay line written more than once per transaction");

endmodule

// ===== design/tcrm_dp.sv =====
// Datapath: configuration registers, comb delay lines, feedback, averaging and blend arithmetic.
// Depends on tcrm_pkg and tcrm_ram.
module tcrm_dp import tcrm_pkg::*; (
	input  logic                        clk,
	input  logic                        arst_n,
	input  ctrl_cmd_t                   cmd,
	output dp_status_t                  status,
	input  logic                        cfg_write,
	input  logic [CFG_IDX_W-1:0]        cfg_index,
	input  logic [CFG_DATA_W-1:0]       cfg_data,
	input  logic signed [SAMPLE_W-1:0]  left_in,
	input  logic signed [SAMPLE_W-1:0]  right_in,
	input  logic                        last_in,
	output logic signed [SAMPLE_W-1:0]  left_out,
	output logic signed [SAMPLE_W-1:0]  right_out,
	output logic                        last_out
);

	logic               enable_q;
	logic [DELAY_W-1:0] delay_q [COMB_COUNT];
	logic [DECAY_W-1:0] decay_q;
	logic [MIX_W-1:0]   mix_q;
	logic [LINE_W-1:0]  wi_q;

	logic signed [SAMPLE_W-1:0] xl_q;
	logic signed [SAMPLE_W-1:0] xr_q;
	logic                       last_q;
	logic                       bypass_q;

	logic [SAMPLE_W-1:0]        rdata [COMB_COUNT];
	logic signed [32:0]         prod_s1 [COMB_COUNT];
	logic signed [SAMPLE_W-1:0] y_d [COMB_COUNT];
	logic signed [SAMPLE_W-1:0] y_q [COMB_COUNT];

	logic signed [SUM_W-1:0]    sum;
	logic signed [20:0]         divn_full;
	logic [DIVP_W-1:0]          div_s2;
	logic [QUOT_W-1:0]          quot;
	logic signed [SAMPLE_W-1:0] wet;
	logic [MIX_W-1:0]           mix_c;
	logic [MIX_W-1:0]           dry;
	logic signed [33:0]         pl_s3;
	logic signed [33:0]         pr_s3;
	logic signed [33:0]         pw_s3;
	logic signed [34:0]         bl_sum;
	logic signed [34:0]         br_sum;
	logic signed [SAMPLE_W-1:0] bl;
	logic signed [SAMPLE_W-1:0] br;

	logic signed [SAMPLE_W-1:0] left_q;
	logic signed [SAMPLE_W-1:0] right_q;
	logic                       lastout_q;

	assign status.enable = enable_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b0;
			for (int k = 0; k < COMB_COUNT; k++) begin
				delay_q[k] <= DELAY_RESET;
			end
			decay_q <= '0;
			mix_q   <= '0;
			wi_q    <= '0;
		end else begin
			if (cfg_write) begin
				case (cfg_index)
					CFG_ENABLE: enable_q   <= cfg_data[0];
					CFG_DELAY0: delay_q[0] <= cfg_data[DELAY_W-1:0];
					CFG_DELAY1: delay_q[1] <= cfg_data[DELAY_W-1:0];
					CFG_DELAY2: delay_q[2] <= cfg_data[DELAY_W-1:0];
					CFG_DECAY:  decay_q    <= cfg_data[DECAY_W-1:0];
					CFG_MIX:    mix_q      <= cfg_data[MIX_W-1:0];
					default: begin
					end
				endcase
			end
			if (cmd.acc) begin
				wi_q <= wi_q + LINE_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			xl_q     <= left_in;
			xr_q     <= right_in;
			last_q   <= last_in;
			bypass_q <= !enable_q;
		end
	end

	for (genvar k = 0; k < COMB_COUNT; k++) begin : g_comb
		logic signed [33:0] acc;
		logic [LINE_W-1:0]  raddr;

		assign raddr = wi_q - delay_q[k][LINE_W-1:0];

		tcrm_ram #(
			.WIDTH(SAMPLE_W),
			.DEPTH(LINE_DEPTH)
		) u_line (
			.clk  (clk),
			.we   (cmd.clear | cmd.acc),
			.waddr(cmd.clear ? cmd.clr_addr : wi_q),
			.wdata(cmd.clear ? '0 : y_d[k]),
			.raddr(raddr),
			.rdata(rdata[k])
		);

		always_ff @(posedge clk) begin
			if (cmd.mul) begin
				prod_s1[k] <= $signed(rdata[k]) * $signed({1'b0, decay_q});
			end
			if (cmd.acc) begin
				y_q[k] <= y_d[k];
			end
		end

		always_comb begin
			acc = $signed({{3{xl_q[SAMPLE_W-1]}}, xl_q, 15'b0})
				+ $signed({prod_s1[k][32], prod_s1[k]})
				+ 34'sd32768;
			y_d[k] = sat16($signed({{2{acc[33]}}, acc[33:16]}));
		end
	end

	always_comb begin
		sum = '0;
		for (int k = 0; k < COMB_COUNT; k++) begin
			sum = sum + SUM_W'(y_q[k]);
		end
		divn_full = ($signed({{3{sum[SUM_W-1]}}, sum}) <<< 1) + DIV_BIAS;
	end

	always_ff @(posedge clk) begin
		if (cmd.div) begin
			div_s2 <= DIVP_W'(divn_full[DIVN_W-1:0]) * DIVP_W'(DIV_RECIP);
		end
	end

	assign quot  = div_s2[DIVP_W-1:DIV_SHIFT];
	assign wet   = $signed(SAMPLE_W'(quot - DIV_OFFSET));
	assign mix_c = (mix_q > MIX_FULL) ? MIX_FULL : mix_q;
	assign dry   = MIX_FULL - mix_c;

	always_ff @(posedge clk) begin
		if (cmd.mix) begin
			pl_s3 <= xl_q * $signed({1'b0, dry});
			pr_s3 <= xr_q * $signed({1'b0, dry});
			pw_s3 <= wet * $signed({1'b0, mix_c});
		end
	end

	always_comb begin
		bl_sum = $signed({pl_s3[33], pl_s3}) + $signed({pw_s3[33], pw_s3}) + 35'sd32768;
		br_sum = $signed({pr_s3[33], pr_s3}) + $signed({pw_s3[33], pw_s3}) + 35'sd32768;
		bl     = sat16($signed({bl_sum[34], bl_sum[34:16]}));
		br     = sat16($signed({br_sum[34], br_sum[34:16]}));
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			left_q    <= bypass_q ? xl_q : bl;
			right_q   <= bypass_q ? xr_q : br;
			lastout_q <= last_q;
		end
	end

	assign left_out  = left_q;
	assign right_out = right_q;
	assign last_out  = lastout_q;

endmodule

// ===== design/triple_comb_resonator_mix.sv =====
// Top level of the triple comb resonator mix block: controller plus datapath.
// Depends on tcrm_pkg, tcrm_ctrl, tcrm_dp.
//
// After reset the block zeroes its three delay lines (one row of all three lines per cycle) and
// holds in_stall high meanwhile; configuration writes are taken at any time.
// One frame at a time: an enabled frame passes from acceptance to the output register through
// these steps in order (delay line read at acceptance, then feedback multiply, saturate and write
// back, divide by three, blend multiply, round and load), and the next frame can be accepted in
// the cycle after the load. A disabled frame skips these steps and goes from acceptance straight
// to the load. A stalled output register holds the load and keeps in_stall high.
// A finished frame waits in the output register while the next frame is accepted.
module triple_comb_resonator_mix import tcrm_pkg::*; (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic signed [SAMPLE_W-1:0]  left_in,
	input  logic signed [SAMPLE_W-1:0]  right_in,
	input  logic                        last_in,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic signed [SAMPLE_W-1:0]  left_out,
	output logic signed [SAMPLE_W-1:0]  right_out,
	output logic                        last_out,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [CFG_IDX_W-1:0]        cfg_index,
	input  logic [CFG_DATA_W-1:0]       cfg_data
);

	ctrl_cmd_t  cmd;
	dp_status_t status;

	assign cfg_ready = 1'b1;

	tcrm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status   (status),
		.cmd      (cmd)
	);

	tcrm_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.status   (status),
		.cfg_write(cfg_valid & cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.left_in  (left_in),
		.right_in (right_in),
		.last_in  (last_in),
		.left_out (left_out),
		.right_out(right_out),
		.last_out (last_out)
	);

endmodule
